### src/dense_handle_pool_defines.svh
// ----------------------------------------------------------------------------
// dense_handle_pool_defines.svh
// Assertion macros used by the dense handle pool checker.
// ----------------------------------------------------------------------------
`ifndef DENSE_HANDLE_POOL_DEFINES_SVH
`define DENSE_HANDLE_POOL_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define DHP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define DHP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/dhp_pkg.sv
// ----------------------------------------------------------------------------
// dhp_pkg
// Types and codes of the dense handle pool.
// ----------------------------------------------------------------------------
package dhp_pkg;

    localparam int HANDLE_W = 10;
    localparam int POS_W    = 10;
    localparam int COUNT_W  = 11;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE_POS = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE_HDL = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_POS  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_LIVE = 2'd3;

    // Command beat
    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [POS_W-1:0]    position;
        logic [HANDLE_W-1:0] handle;
    } t_cmd;

    // Result beat
    typedef struct packed {
        logic [HANDLE_W-1:0] granted_handle;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  live_count;
    } t_result;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_SCAN,
        S_SW_RD0,
        S_SW_RD1,
        S_SW_WR0,
        S_SW_WR1
    } t_state;

endpackage

### src/dense_handle_pool.sv
// Full, bad position and unused commands answer from idle; allocate passes S_ALLOC; free
// by position runs S_SW_RD0 through S_SW_WR1; free by handle scans the live entries
// downward (one table read per cycle) and swaps on a match or reports not live. Next
// start is taken in the cycle the result strobe is high; one command at a time, the
// receiver cannot stall. Reset clears state, done, live count and the high-water mark;
// entries at or above the mark read as their own index, so no clearing pass runs.
// ----------------------------------------------------------------------------
// dense_handle_pool
// Packed handle table with allocate, free by position and free by handle,
// run by a small sequencer around one table RAM.
// ----------------------------------------------------------------------------
module dense_handle_pool #(
    parameter int SLOTS = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  dhp_pkg::t_cmd    i_cmd,
    output logic             o_busy,
    output logic             o_done,
    output dhp_pkg::t_result o_result
);
    import dhp_pkg::*;

    localparam int AW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_hwm, n_hwm;
    logic [CW-1:0]       r_idx, n_idx;
    logic [AW-1:0]       r_pos, n_pos;
    logic [HANDLE_W-1:0] r_hdl, n_hdl;
    logic [HANDLE_W-1:0] r_val_a, n_val_a;
    logic [AW-1:0]       r_rd_addr, n_rd_addr;
    logic                r_rd_fresh, n_rd_fresh;
    logic                r_rd_vld, n_rd_vld;
    logic                r_done, n_done;
    t_result             r_result, n_result;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [HANDLE_W-1:0] ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [HANDLE_W-1:0] ram_q;
    logic [HANDLE_W-1:0] rd_value;
    logic [CW-1:0]       idx_m1;

    // Handle table
    dhp_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // Entries at or above the high-water mark were never written: they read as their index
    assign rd_value = r_rd_fresh ? HANDLE_W'(r_rd_addr) : ram_q;
    assign idx_m1   = r_idx - 1'b1;

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_hwm    <= '0;
            r_rd_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_hwm    <= n_hwm;
            r_rd_vld <= n_rd_vld;
            r_done   <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_pos      <= n_pos;
        r_hdl      <= n_hdl;
        r_val_a    <= n_val_a;
        r_rd_addr  <= n_rd_addr;
        r_rd_fresh <= n_rd_fresh;
        r_result   <= n_result;
    end

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_hwm      = r_hwm;
        n_idx      = r_idx;
        n_pos      = r_pos;
        n_hdl      = r_hdl;
        n_val_a    = r_val_a;
        n_rd_vld   = r_rd_vld;
        n_done     = 1'b0;
        n_result   = r_result;
        ram_we     = 1'b0;
        ram_waddr  = r_pos;
        ram_wdata  = rd_value;
        ram_re     = 1'b0;
        ram_raddr  = r_pos;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_cmd.command)
                        CMD_ALLOC: begin
                            if (r_count < CW'(SLOTS)) begin
                                ram_re    = 1'b1;
                                ram_raddr = r_count[AW-1:0];
                                n_state   = S_ALLOC;
                            end else begin
                                n_done   = 1'b1;
                                n_result = '{granted_handle: '0, status: ST_FULL,
                                             live_count: COUNT_W'(r_count)};
                            end
                        end
                        CMD_FREE_POS: begin
                            if (CMP_W'(i_cmd.position) < CMP_W'(r_count)) begin
                                n_pos   = AW'(i_cmd.position);
                                n_count = r_count - 1'b1;
                                n_state = S_SW_RD0;
                            end else begin
                                n_done   = 1'b1;
                                n_result = '{granted_handle: '0, status: ST_BAD_POS,
                                             live_count: COUNT_W'(r_count)};
                            end
                        end
                        CMD_FREE_HDL: begin
                            n_hdl    = i_cmd.handle;
                            n_idx    = r_count;
                            n_rd_vld = 1'b0;
                            n_state  = S_SCAN;
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_result = '{granted_handle: '0, status: ST_OK,
                                         live_count: COUNT_W'(r_count)};
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                // first touch of this entry: store its index so the mark can move up
                if (r_rd_fresh) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_rd_addr;
                    ram_wdata = rd_value;
                    n_hwm     = r_count + 1'b1;
                end
                n_count  = r_count + 1'b1;
                n_done   = 1'b1;
                n_result = '{granted_handle: rd_value, status: ST_OK,
                             live_count: COUNT_W'(r_count + 1'b1)};
                n_state  = S_IDLE;
            end
            S_SCAN: begin
                // compare the entry read last cycle while the next one is fetched
                n_rd_vld = 1'b0;
                if (r_rd_vld && (rd_value == r_hdl)) begin
                    n_pos   = r_rd_addr;
                    n_count = r_count - 1'b1;
                    n_state = S_SW_RD0;
                end else if (r_idx != '0) begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_m1[AW-1:0];
                    n_idx     = idx_m1;
                    n_rd_vld  = 1'b1;
                end else begin
                    n_done   = 1'b1;
                    n_result = '{granted_handle: '0, status: ST_NOT_LIVE,
                                 live_count: COUNT_W'(r_count)};
                    n_state  = S_IDLE;
                end
            end
            S_SW_RD0: begin
                ram_re    = 1'b1;
                ram_raddr = r_pos;
                n_state   = S_SW_RD1;
            end
            S_SW_RD1: begin
                // count already holds the last live position
                ram_re    = 1'b1;
                ram_raddr = r_count[AW-1:0];
                n_val_a   = rd_value;
                n_state   = S_SW_WR0;
            end
            S_SW_WR0: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos;
                ram_wdata = rd_value;
                n_state   = S_SW_WR1;
            end
            S_SW_WR1: begin
                ram_we    = 1'b1;
                ram_waddr = r_count[AW-1:0];
                ram_wdata = r_val_a;
                n_done    = 1'b1;
                n_result  = '{granted_handle: '0, status: ST_OK,
                              live_count: COUNT_W'(r_count)};
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Read-side bookkeeping for the table RAM
    always_comb begin
        n_rd_addr  = r_rd_addr;
        n_rd_fresh = r_rd_fresh;
        if (ram_re) begin
            n_rd_addr  = ram_raddr;
            n_rd_fresh = (CW'(ram_raddr) >= r_hwm);
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

### src/dhp_ram.sv
// ----------------------------------------------------------------------------
// dhp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dhp_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/dhp_checker.sv
// ----------------------------------------------------------------------------
// dhp_checker
// Port-level assertions for the dense handle pool, bound to the top level.
// ----------------------------------------------------------------------------
`include "dense_handle_pool_defines.svh"

module dhp_checker #(
    parameter int SLOTS = 1024
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_start,
    input logic             o_busy,
    input logic             o_done,
    input dhp_pkg::t_result o_result
);
    import dhp_pkg::*;

    // An accepted command either runs or answers at once
    `DHP_ASSERT_NEXT(a_accept_moves, i_start && !o_busy, o_busy || o_done, "accept ignored")

    // A result beat follows a start beat or a running command
    `DHP_ASSERT_SAME(a_done_cause, o_done, $past(o_busy || i_start), "spurious result beat")

    // Only a successful beat may carry a handle
    `DHP_ASSERT_SAME(a_grant_zero, o_done && (o_result.status != ST_OK),
                     o_result.granted_handle == '0, "handle on failed beat")

    // Live count never passes the pool size
    `DHP_ASSERT_SAME(a_count_bound, o_done, int'(o_result.live_count) <= SLOTS,
                     "live count above pool size")

endmodule

bind dense_handle_pool dhp_checker #(
    .SLOTS (SLOTS)
) u_dhp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_done   (o_done),
    .o_result (o_result)
);
